[rtl/vdp_sheet_resistance_solver_macros.svh]
// Assertion macros used by the solver RTL.
`ifndef VDP_SHEET_RESISTANCE_SOLVER_MACROS_SVH
`define VDP_SHEET_RESISTANCE_SOLVER_MACROS_SVH
`ifndef ASSERT_OFF
`define VDP_ASSERT_NOW(lbl, clk, rst_n, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("vdp assertion failed");
`define VDP_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("vdp assertion failed");
`else
`define VDP_ASSERT_NOW(lbl, clk, rst_n, ante, cons)
`define VDP_ASSERT_NEXT(lbl, clk, rst_n, ante, cons)
`endif
`endif

[rtl/vdp_pkg.sv]
package vdp_pkg;

	localparam int RES_W   = 32;
	localparam int RS_W    = 52;
	localparam int SHEET_W = 36;
	localparam int EXP_W   = 32;
	localparam int LIMIT_W = 6;
	localparam int TOL_W   = 5;
	localparam int STEP_W  = 6;
	localparam int STAT_W  = 2;
	localparam int OP_W    = 4;

	localparam logic [63:0] PI_Q60    = 64'h3243F6A8885A308D;
	localparam logic [63:0] LN2_Q60   = 64'h0B17217F7D1CF79B;
	localparam logic [63:0] LN2_Q56   = 64'h00B17217F7D1CF7A;
	localparam logic [63:0] ONE_Q56   = 64'h0100000000000000;
	localparam logic [63:0] T_CLAMP   = 64'h3200000000000000;
	localparam logic [63:0] RS_MIN64  = 64'h0000000000010000;
	localparam logic [63:0] RS_MAX64  = 64'h000FFFFFFFFFFFFF;
	localparam logic [32:0] ONE_E     = 33'h040000000;
	localparam logic [6:0]  EXP_SHIFT = 7'd26;
	localparam logic [63:0] K_ZERO    = 64'd38;
	localparam logic [4:0]  EXP_TERMS = 5'd20;

	localparam logic [LIMIT_W-1:0] LIMIT_RST = 6'd50;
	localparam logic [TOL_W-1:0]   TOL_RST   = 5'd23;

	localparam logic REG_LIMIT = 1'b0;
	localparam logic REG_TOL   = 1'b1;

	localparam logic [STAT_W-1:0] ST_CONV      = 2'd0;
	localparam logic [STAT_W-1:0] ST_NONPOS    = 2'd1;
	localparam logic [STAT_W-1:0] ST_LIMIT     = 2'd2;
	localparam logic [STAT_W-1:0] ST_UNDERFLOW = 2'd3;

	localparam logic [OP_W-1:0] OP_GUESS_MUL = 4'd0;
	localparam logic [OP_W-1:0] OP_GUESS_DIV = 4'd1;
	localparam logic [OP_W-1:0] OP_RATIO_MUL = 4'd2;
	localparam logic [OP_W-1:0] OP_RATIO_DIV = 4'd3;
	localparam logic [OP_W-1:0] OP_EXP_RED   = 4'd4;
	localparam logic [OP_W-1:0] OP_EXP_MUL   = 4'd5;
	localparam logic [OP_W-1:0] OP_EXP_SDIV  = 4'd6;
	localparam logic [OP_W-1:0] OP_EXP_FIN   = 4'd7;
	localparam logic [OP_W-1:0] OP_G_MUL     = 4'd8;
	localparam logic [OP_W-1:0] OP_DELTA_MUL = 4'd9;
	localparam logic [OP_W-1:0] OP_DELTA_DIV = 4'd10;

	typedef struct packed {
		logic            go;
		logic            load;
		logic [OP_W-1:0] op;
		logic            side;
	} vdp_cmd_t;

	typedef struct packed {
		logic done;
		logic nonpos;
		logic g_zero;
		logic conv;
		logic n_last;
	} vdp_stat_t;

endpackage

[rtl/vdp_dp.sv]
module vdp_dp (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic signed [vdp_pkg::RES_W-1:0]   resistance_a,
	input  logic signed [vdp_pkg::RES_W-1:0]   resistance_b,
	input  logic [vdp_pkg::TOL_W-1:0]          tolerance_shift,
	input  vdp_pkg::vdp_cmd_t                  cmd,
	output vdp_pkg::vdp_stat_t                 stat,
	output logic [vdp_pkg::SHEET_W-1:0]        sheet_resistance
);

	// operand and result registers
	logic [vdp_pkg::RES_W-1:0] ra_q, rb_q;
	logic [vdp_pkg::RS_W-1:0]  rs_q;
	logic [63:0]               ta_q, tb_q, r_q, p_q, g_q;
	logic [vdp_pkg::EXP_W-1:0] ea_q, eb_q;
	logic [5:0]                k_q;
	logic                      kz_q;
	logic [4:0]                n_q;
	logic                      conv_q;
	logic [vdp_pkg::OP_W-1:0]  op_q;
	logic                      side_q;
	logic                      done_q;

	// shared multiplier: four 32x32 passes into a 128-bit accumulator
	logic [63:0]  ma_q, mb_q, pp_s1;
	logic [1:0]   mcnt_q, ppsh_s1;
	logic         mrun_q, ppv_s1;
	logic [127:0] acc_q, pp_ext;
	logic [31:0]  mh_a, mh_b;
	logic [63:0]  mprod;
	logic         mul_last;

	// shared divider: 128/64 restoring, one quotient bit per cycle
	logic [63:0] drem_q, dlo_q, dden_q, dq_q;
	logic [5:0]  dcnt_q;
	logic        drun_q, dfin_q;
	logic [63:0] dr2, dsub;
	logic        dge;

	// small divider by the series index, eight bits per cycle
	logic [63:0] sx_q, sq_q;
	logic [4:0]  sn_q, srem_q, sd_rem_n;
	logic [2:0]  scnt_q;
	logic        srun_q, sfin_q;
	logic [7:0]  sd_qb;
	logic [5:0]  sd_r;

	logic        nonpos;
	logic [63:0] t_sel;
	logic [vdp_pkg::EXP_W-1:0] e_sel;
	logic [32:0] e_sum, fmag_w;
	logic        down;
	logic        is_mul, mul_clr, is_div;
	logic [63:0] mul_a_n, mul_b_n, div_den;
	logic [127:0] div_num;
	logic        div_sat;
	logic [63:0] rs64, rs_upd, guess_n, ratio_n, p_sh;
	logic        conv_n;
	logic [6:0]  sh_amt;

	assign nonpos = (resistance_a == '0) || (resistance_b == '0) ||
		resistance_a[vdp_pkg::RES_W-1] || resistance_b[vdp_pkg::RES_W-1];

	assign t_sel = cmd.side ? tb_q : ta_q;
	assign e_sel = cmd.side ? eb_q : ea_q;

	assign e_sum  = {1'b0, ea_q} + {1'b0, eb_q};
	assign down   = e_sum >= vdp_pkg::ONE_E;
	assign fmag_w = down ? (e_sum - vdp_pkg::ONE_E) : (vdp_pkg::ONE_E - e_sum);

	always_comb begin
		is_mul  = 1'b1;
		mul_clr = 1'b1;
		mul_a_n = '0;
		mul_b_n = '0;
		case (cmd.op)
			vdp_pkg::OP_GUESS_MUL: begin
				mul_a_n = vdp_pkg::PI_Q60;
				mul_b_n = {31'b0, {1'b0, ra_q} + {1'b0, rb_q}};
			end
			vdp_pkg::OP_RATIO_MUL: begin
				mul_a_n = vdp_pkg::PI_Q60;
				mul_b_n = {32'b0, cmd.side ? rb_q : ra_q};
			end
			vdp_pkg::OP_EXP_MUL: begin
				mul_a_n = r_q;
				mul_b_n = p_q;
			end
			vdp_pkg::OP_G_MUL: begin
				mul_a_n = t_sel;
				mul_b_n = {32'b0, e_sel};
				mul_clr = !cmd.side;
			end
			vdp_pkg::OP_DELTA_MUL: begin
				mul_a_n = {32'b0, fmag_w[31:0]};
				mul_b_n = {12'b0, rs_q};
			end
			default: is_mul = 1'b0;
		endcase
	end

	always_comb begin
		is_div  = 1'b1;
		div_num = '0;
		div_den = '0;
		case (cmd.op)
			vdp_pkg::OP_GUESS_DIV: begin
				div_num = {acc_q[112:0], 15'b0};
				div_den = vdp_pkg::LN2_Q60;
			end
			vdp_pkg::OP_RATIO_DIV: begin
				div_num = {acc_q[115:0], 12'b0};
				div_den = {12'b0, rs_q};
			end
			vdp_pkg::OP_EXP_RED: begin
				div_num = {64'b0, t_sel};
				div_den = vdp_pkg::LN2_Q56;
			end
			vdp_pkg::OP_DELTA_DIV: begin
				div_num = {acc_q[111:0], 16'b0};
				div_den = g_q;
			end
			default: is_div = 1'b0;
		endcase
	end

	assign div_sat = (div_den == '0) || (div_num[127:64] >= div_den);

	assign mh_a     = mcnt_q[1] ? ma_q[63:32] : ma_q[31:0];
	assign mh_b     = mcnt_q[0] ? mb_q[63:32] : mb_q[31:0];
	assign mprod    = 64'(mh_a) * 64'(mh_b);
	assign mul_last = ppv_s1 && (ppsh_s1 == 2'd3);

	always_comb begin
		case (ppsh_s1) inside
			2'd0:       pp_ext = {64'b0, pp_s1};
			2'd1, 2'd2: pp_ext = {32'b0, pp_s1, 32'b0};
			default:    pp_ext = {pp_s1, 64'b0};
		endcase
	end

	assign dr2  = {drem_q[62:0], dlo_q[63]};
	assign dge  = drem_q[63] || (dr2 >= dden_q);
	assign dsub = dr2 - dden_q;

	always_comb begin
		sd_rem_n = srem_q;
		sd_qb    = '0;
		sd_r     = '0;
		for (int i = 7; i >= 0; i--) begin
			sd_r = {sd_rem_n, sx_q[56+i]};
			if (sd_r >= {1'b0, sn_q}) begin
				sd_r     = sd_r - {1'b0, sn_q};
				sd_qb[i] = 1'b1;
			end
			sd_rem_n = sd_r[4:0];
		end
	end

	// result clamps and the Newton update
	always_comb begin
		if (dq_q > vdp_pkg::RS_MAX64)
			guess_n = vdp_pkg::RS_MAX64;
		else if (dq_q < vdp_pkg::RS_MIN64)
			guess_n = vdp_pkg::RS_MIN64;
		else
			guess_n = dq_q;
		ratio_n = (dq_q > vdp_pkg::T_CLAMP) ? vdp_pkg::T_CLAMP : dq_q;
		rs64 = {12'b0, rs_q};
		if (down) begin
			if (dq_q >= rs64 - vdp_pkg::RS_MIN64)
				rs_upd = vdp_pkg::RS_MIN64;
			else
				rs_upd = rs64 - dq_q;
		end else begin
			if (dq_q >= vdp_pkg::RS_MAX64 - rs64)
				rs_upd = vdp_pkg::RS_MAX64;
			else
				rs_upd = rs64 + dq_q;
		end
		conv_n = (dq_q == '0) || (dq_q < (rs_upd >> tolerance_shift));
	end

	assign sh_amt = {1'b0, k_q} + vdp_pkg::EXP_SHIFT;
	assign p_sh   = p_q >> sh_amt;

	// unit sequencing
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mrun_q <= 1'b0;
			mcnt_q <= '0;
			ppv_s1 <= 1'b0;
			drun_q <= 1'b0;
			dcnt_q <= '0;
			dfin_q <= 1'b0;
			srun_q <= 1'b0;
			scnt_q <= '0;
			sfin_q <= 1'b0;
			done_q <= 1'b0;
		end else begin
			done_q <= mul_last || dfin_q || sfin_q ||
				(cmd.go && (cmd.op == vdp_pkg::OP_EXP_FIN));
			dfin_q <= 1'b0;
			sfin_q <= 1'b0;
			ppv_s1 <= mrun_q;
			if (mrun_q) begin
				mcnt_q <= mcnt_q + 2'd1;
				if (mcnt_q == 2'd3)
					mrun_q <= 1'b0;
			end
			if (drun_q) begin
				dcnt_q <= dcnt_q - 6'd1;
				if (dcnt_q == '0) begin
					drun_q <= 1'b0;
					dfin_q <= 1'b1;
				end
			end
			if (srun_q) begin
				scnt_q <= scnt_q + 3'd1;
				if (scnt_q == 3'd7) begin
					srun_q <= 1'b0;
					sfin_q <= 1'b1;
				end
			end
			if (cmd.go && is_mul) begin
				mrun_q <= 1'b1;
				mcnt_q <= '0;
			end
			if (cmd.go && is_div) begin
				if (div_sat) begin
					dfin_q <= 1'b1;
				end else begin
					drun_q <= 1'b1;
					dcnt_q <= 6'd63;
				end
			end
			if (cmd.go && (cmd.op == vdp_pkg::OP_EXP_SDIV)) begin
				srun_q <= 1'b1;
				scnt_q <= '0;
			end
		end
	end

	// data path registers
	always_ff @(posedge clk) begin
		if (cmd.load) begin
			ra_q <= resistance_a;
			rb_q <= resistance_b;
			rs_q <= '0;
		end
		if (cmd.go) begin
			op_q   <= cmd.op;
			side_q <= cmd.side;
			if (is_mul) begin
				ma_q <= mul_a_n;
				mb_q <= mul_b_n;
				if (mul_clr)
					acc_q <= '0;
			end
			if (cmd.op == vdp_pkg::OP_DELTA_MUL)
				g_q <= acc_q[103:40];
			if (is_div) begin
				if (div_sat) begin
					dq_q <= '1;
				end else begin
					drem_q <= div_num[127:64];
					dlo_q  <= div_num[63:0];
					dden_q <= div_den;
					dq_q   <= '0;
				end
			end
			if (cmd.op == vdp_pkg::OP_EXP_SDIV) begin
				sx_q   <= acc_q[119:56];
				sn_q   <= n_q;
				srem_q <= '0;
				sq_q   <= '0;
			end
			if (cmd.op == vdp_pkg::OP_EXP_FIN) begin
				if (cmd.side)
					eb_q <= kz_q ? '0 : p_sh[vdp_pkg::EXP_W-1:0];
				else
					ea_q <= kz_q ? '0 : p_sh[vdp_pkg::EXP_W-1:0];
			end
		end
		if (mrun_q) begin
			pp_s1   <= mprod;
			ppsh_s1 <= mcnt_q;
		end
		if (ppv_s1)
			acc_q <= acc_q + pp_ext;
		if (drun_q) begin
			drem_q <= dge ? dsub : dr2;
			dlo_q  <= {dlo_q[62:0], 1'b0};
			dq_q   <= {dq_q[62:0], dge};
		end
		if (srun_q) begin
			sx_q   <= {sx_q[55:0], 8'b0};
			srem_q <= sd_rem_n;
			sq_q   <= {sq_q[55:0], sd_qb};
		end
		if (sfin_q) begin
			p_q <= vdp_pkg::ONE_Q56 - sq_q;
			n_q <= n_q - 5'd1;
		end
		if (dfin_q) begin
			case (op_q)
				vdp_pkg::OP_GUESS_DIV: rs_q <= guess_n[vdp_pkg::RS_W-1:0];
				vdp_pkg::OP_RATIO_DIV: begin
					if (side_q)
						tb_q <= ratio_n;
					else
						ta_q <= ratio_n;
				end
				vdp_pkg::OP_EXP_RED: begin
					kz_q <= dq_q >= vdp_pkg::K_ZERO;
					k_q  <= dq_q[5:0];
					r_q  <= drem_q;
					p_q  <= vdp_pkg::ONE_Q56;
					n_q  <= vdp_pkg::EXP_TERMS;
				end
				vdp_pkg::OP_DELTA_DIV: begin
					rs_q   <= rs_upd[vdp_pkg::RS_W-1:0];
					conv_q <= conv_n;
				end
				default: ;
			endcase
		end
	end

	assign stat.done   = done_q;
	assign stat.nonpos = nonpos;
	assign stat.g_zero = acc_q[103:40] == '0;
	assign stat.conv   = conv_q;
	assign stat.n_last = n_q == '0;

	assign sheet_resistance = rs_q[vdp_pkg::RS_W-1:16];

endmodule

[rtl/vdp_ctrl.sv]
module vdp_ctrl (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          start,
	input  logic [vdp_pkg::LIMIT_W-1:0]   iteration_limit,
	input  vdp_pkg::vdp_stat_t            stat,
	output vdp_pkg::vdp_cmd_t             cmd,
	output logic                          busy,
	output logic                          done,
	output logic [vdp_pkg::STAT_W-1:0]    solve_status,
	output logic [vdp_pkg::STEP_W-1:0]    steps_used
);

	localparam logic [3:0] S_IDLE  = 4'd0;
	localparam logic [3:0] S_GMUL  = 4'd1;
	localparam logic [3:0] S_GDIV  = 4'd2;
	localparam logic [3:0] S_RMUL  = 4'd3;
	localparam logic [3:0] S_RDIV  = 4'd4;
	localparam logic [3:0] S_XRED  = 4'd5;
	localparam logic [3:0] S_XMUL  = 4'd6;
	localparam logic [3:0] S_XSDIV = 4'd7;
	localparam logic [3:0] S_XFIN  = 4'd8;
	localparam logic [3:0] S_GM    = 4'd9;
	localparam logic [3:0] S_GCHK  = 4'd10;
	localparam logic [3:0] S_DMUL  = 4'd11;
	localparam logic [3:0] S_DDIV  = 4'd12;

	logic [3:0]                   state_q;
	logic                         wait_q, side_q, done_q;
	logic [vdp_pkg::STAT_W-1:0]   status_q;
	logic [vdp_pkg::STEP_W-1:0]   steps_q, steps_plus;

	assign steps_plus = steps_q + 6'd1;

	always_comb begin
		cmd      = '0;
		cmd.load = start && (state_q == S_IDLE);
		cmd.side = side_q;
		cmd.go   = !wait_q && (state_q != S_IDLE) && (state_q != S_GCHK);
		unique case (state_q)
			S_GMUL:  cmd.op = vdp_pkg::OP_GUESS_MUL;
			S_GDIV:  cmd.op = vdp_pkg::OP_GUESS_DIV;
			S_RMUL:  cmd.op = vdp_pkg::OP_RATIO_MUL;
			S_RDIV:  cmd.op = vdp_pkg::OP_RATIO_DIV;
			S_XRED:  cmd.op = vdp_pkg::OP_EXP_RED;
			S_XMUL:  cmd.op = vdp_pkg::OP_EXP_MUL;
			S_XSDIV: cmd.op = vdp_pkg::OP_EXP_SDIV;
			S_XFIN:  cmd.op = vdp_pkg::OP_EXP_FIN;
			S_GM:    cmd.op = vdp_pkg::OP_G_MUL;
			S_DMUL:  cmd.op = vdp_pkg::OP_DELTA_MUL;
			S_DDIV:  cmd.op = vdp_pkg::OP_DELTA_DIV;
			default: cmd.op = vdp_pkg::OP_GUESS_MUL;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= S_IDLE;
			wait_q   <= 1'b0;
			side_q   <= 1'b0;
			done_q   <= 1'b0;
			status_q <= vdp_pkg::ST_CONV;
			steps_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (cmd.go)
				wait_q <= 1'b1;
			if (stat.done)
				wait_q <= 1'b0;
			unique case (state_q)
				S_IDLE: begin
					if (start) begin
						steps_q <= '0;
						side_q  <= 1'b0;
						if (stat.nonpos) begin
							done_q   <= 1'b1;
							status_q <= vdp_pkg::ST_NONPOS;
						end else begin
							state_q <= S_GMUL;
						end
					end
				end
				S_GMUL: if (stat.done) state_q <= S_GDIV;
				S_GDIV: begin
					if (stat.done) begin
						if (iteration_limit == '0) begin
							state_q  <= S_IDLE;
							done_q   <= 1'b1;
							status_q <= vdp_pkg::ST_LIMIT;
						end else begin
							state_q <= S_RMUL;
						end
					end
				end
				S_RMUL: if (stat.done) state_q <= S_RDIV;
				S_RDIV: begin
					if (stat.done) begin
						side_q  <= !side_q;
						state_q <= side_q ? S_XRED : S_RMUL;
					end
				end
				S_XRED: if (stat.done) state_q <= S_XMUL;
				S_XMUL: if (stat.done) state_q <= S_XSDIV;
				S_XSDIV: if (stat.done) state_q <= stat.n_last ? S_XFIN : S_XMUL;
				S_XFIN: begin
					if (stat.done) begin
						side_q  <= !side_q;
						state_q <= side_q ? S_GM : S_XRED;
					end
				end
				S_GM: begin
					if (stat.done) begin
						side_q  <= !side_q;
						state_q <= side_q ? S_GCHK : S_GM;
					end
				end
				S_GCHK: begin
					if (stat.g_zero) begin
						state_q  <= S_IDLE;
						done_q   <= 1'b1;
						status_q <= vdp_pkg::ST_UNDERFLOW;
					end else begin
						state_q <= S_DMUL;
					end
				end
				S_DMUL: if (stat.done) state_q <= S_DDIV;
				S_DDIV: begin
					if (stat.done) begin
						steps_q <= steps_plus;
						if (stat.conv) begin
							state_q  <= S_IDLE;
							done_q   <= 1'b1;
							status_q <= vdp_pkg::ST_CONV;
						end else if (steps_plus == iteration_limit) begin
							state_q  <= S_IDLE;
							done_q   <= 1'b1;
							status_q <= vdp_pkg::ST_LIMIT;
						end else begin
							state_q <= S_RMUL;
						end
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	assign busy         = state_q != S_IDLE;
	assign done         = done_q;
	assign solve_status = status_q;
	assign steps_used   = steps_q;

endmodule

[rtl/vdp_sheet_resistance_solver.sv]
// Van der Pauw sheet resistance solver. A request is taken at a clock edge where start is
// high and busy is low; resistance_a and resistance_b are sampled at that edge as signed
// milliohms. The answer appears for exactly one cycle with done high, carrying the sheet
// resistance in milliohms per square, a status code and the number of Newton steps used.
// The receiver cannot stall the block, so done must be captured in the cycle it is shown.
// A request with a zero or negative resistance is answered in the cycle after it is taken.
// Otherwise the solve runs a first guess and then Newton steps. The run time is set by
// the shared 128/64 divider, which produces one quotient bit per cycle, by the shared
// multiplier, which builds each 64x64 product from four 32x32 passes, and by the 20-term
// series for each of the two exponentials. Only one request is in flight at a time.

`include "vdp_sheet_resistance_solver_macros.svh"

module vdp_sheet_resistance_solver (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              start,
	output logic                              busy,
	input  logic signed [vdp_pkg::RES_W-1:0]  resistance_a,
	input  logic signed [vdp_pkg::RES_W-1:0]  resistance_b,
	output logic                              done,
	output logic [vdp_pkg::SHEET_W-1:0]       sheet_resistance,
	output logic [vdp_pkg::STAT_W-1:0]        solve_status,
	output logic [vdp_pkg::STEP_W-1:0]        steps_used,
	input  logic                              psel,
	input  logic                              penable,
	input  logic                              pwrite,
	input  logic [2:0]                        paddr,
	input  logic [31:0]                       pwdata,
	output logic [31:0]                       prdata,
	output logic                              pready
);

	// Configuration registers. Each register sits on a four-byte boundary and the low
	// address bits are ignored, so paddr[2] alone picks the register.
	logic [vdp_pkg::LIMIT_W-1:0] limit_q;
	logic [vdp_pkg::TOL_W-1:0]   tol_q;
	logic                        cfg_wr;

	vdp_pkg::vdp_cmd_t  cmd;
	vdp_pkg::vdp_stat_t stat;

	assign pready = 1'b1;
	assign cfg_wr = psel && penable && pwrite;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			limit_q <= vdp_pkg::LIMIT_RST;
			tol_q   <= vdp_pkg::TOL_RST;
		end else if (cfg_wr) begin
			unique case (paddr[2])
				vdp_pkg::REG_LIMIT: limit_q <= pwdata[vdp_pkg::LIMIT_W-1:0];
				vdp_pkg::REG_TOL:   tol_q   <= pwdata[vdp_pkg::TOL_W-1:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		unique case (paddr[2])
			vdp_pkg::REG_LIMIT: prdata = {26'b0, limit_q};
			vdp_pkg::REG_TOL:   prdata = {27'b0, tol_q};
			default:            prdata = '0;
		endcase
	end

	// The controller walks through the Newton sequence and issues one operation at a
	// time; the datapath owns the arithmetic units and all numeric state.
	vdp_ctrl u_ctrl (
		.clk             (clk),
		.arst_n          (arst_n),
		.start           (start),
		.iteration_limit (limit_q),
		.stat            (stat),
		.cmd             (cmd),
		.busy            (busy),
		.done            (done),
		.solve_status    (solve_status),
		.steps_used      (steps_used)
	);

	vdp_dp u_dp (
		.clk              (clk),
		.arst_n           (arst_n),
		.resistance_a     (resistance_a),
		.resistance_b     (resistance_b),
		.tolerance_shift  (tol_q),
		.cmd              (cmd),
		.stat             (stat),
		.sheet_resistance (sheet_resistance)
	);

	// A result is only shown once the controller is back at rest.
	`VDP_ASSERT_NOW(a_done_idle, clk, arst_n, done, !busy)
	// An accepted request either starts a solve or is answered at once.
	`VDP_ASSERT_NEXT(a_accept_moves, clk, arst_n, start && !busy, busy || done)
	// A rejected request reports zero resistance and no steps.
	`VDP_ASSERT_NOW(a_nonpos_zero, clk, arst_n, done && solve_status == vdp_pkg::ST_NONPOS, sheet_resistance == '0 && steps_used == '0)

endmodule
